/* rtl/core/mpdfa_pkg.sv */
package mpdfa_pkg;

  localparam int unsigned REQ_W     = 3;
  localparam int unsigned STATE_W   = 12;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned LIST_W    = 13;
  localparam int unsigned PID_W     = 12;
  localparam int unsigned END_POS_W = 32;

  localparam int unsigned STATE_TOTAL  = 1 << STATE_W;
  localparam int unsigned ALPHABET     = 1 << BYTE_W;
  localparam int unsigned LIST_DEPTH   = 1 << LIST_W;
  localparam int unsigned PID_TOTAL    = 1 << PID_W;
  localparam int unsigned TRANS_DEPTH  = STATE_TOTAL * ALPHABET;
  localparam int unsigned TRANS_AW     = STATE_W + BYTE_W;

  localparam logic [CNT_W-1:0] MAX_OUTPUTS = CNT_W'(16);

  localparam logic [REQ_W-1:0] REQ_LOAD_TRANS = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_OUT   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_LOAD_LIST  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LOAD_REMAP = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SCAN       = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [STATE_W-1:0] state_index;
    logic [BYTE_W-1:0]  byte_value;
    logic [STATE_W-1:0] next_state;
    logic [CNT_W-1:0]   out_count;
    logic [LIST_W-1:0]  out_offset;
    logic [LIST_W-1:0]  list_index;
    logic [PID_W-1:0]   local_pid;
    logic [PID_W-1:0]   global_id;
    logic               text_end;
  } req_t;

  typedef struct packed {
    logic [END_POS_W-1:0] end_pos;
    logic [PID_W-1:0]     match_pid;
    logic                 last_match;
  } res_t;

  typedef struct packed {
    logic                trans_en;
    logic [TRANS_AW-1:0] trans_addr;
    logic                info_en;
    logic [STATE_W-1:0]  info_addr;
    logic                list_en;
    logic [LIST_W-1:0]   list_addr;
    logic                remap_en;
    logic [PID_W-1:0]    remap_addr;
  } tbl_rd_t;

  typedef struct packed {
    logic [STATE_W-1:0] next_state;
    logic [CNT_W-1:0]   match_count;
    logic [LIST_W-1:0]  match_offset;
    logic [PID_W-1:0]   local_pid;
    logic [PID_W-1:0]   global_id;
  } tbl_rdata_t;

endpackage

/* rtl/core/mpdfa_tables.sv */
module mpdfa_tables (
  input  logic                  clk_i,
  input  logic                  load_en_i,
  input  mpdfa_pkg::req_t       req_i,
  input  mpdfa_pkg::tbl_rd_t    rd_i,
  output mpdfa_pkg::tbl_rdata_t rdata_o
);

  localparam int unsigned INFO_W = mpdfa_pkg::CNT_W + mpdfa_pkg::LIST_W;

  logic [mpdfa_pkg::STATE_W-1:0] trans_mem [0:mpdfa_pkg::TRANS_DEPTH-1];
  logic [INFO_W-1:0]             info_mem  [0:mpdfa_pkg::STATE_TOTAL-1];
  logic [mpdfa_pkg::PID_W-1:0]   list_mem  [0:mpdfa_pkg::LIST_DEPTH-1];
  logic [mpdfa_pkg::PID_W-1:0]   remap_mem [0:mpdfa_pkg::PID_TOTAL-1];

  logic [mpdfa_pkg::STATE_W-1:0] trans_rd_q;
  logic [INFO_W-1:0]             info_rd_q;
  logic [mpdfa_pkg::PID_W-1:0]   list_rd_q;
  logic [mpdfa_pkg::PID_W-1:0]   remap_rd_q;

  always_ff @(posedge clk_i) begin
    if (load_en_i && req_i.req_type == mpdfa_pkg::REQ_LOAD_TRANS) begin
      trans_mem[{req_i.state_index, req_i.byte_value}] <= req_i.next_state;
    end
    if (rd_i.trans_en) begin
      trans_rd_q <= trans_mem[rd_i.trans_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i && req_i.req_type == mpdfa_pkg::REQ_LOAD_OUT) begin
      info_mem[req_i.state_index] <= {req_i.out_count, req_i.out_offset};
    end
    if (rd_i.info_en) begin
      info_rd_q <= info_mem[rd_i.info_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i && req_i.req_type == mpdfa_pkg::REQ_LOAD_LIST) begin
      list_mem[req_i.list_index] <= req_i.local_pid;
    end
    if (rd_i.list_en) begin
      list_rd_q <= list_mem[rd_i.list_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i && req_i.req_type == mpdfa_pkg::REQ_LOAD_REMAP) begin
      remap_mem[req_i.local_pid] <= req_i.global_id;
    end
    if (rd_i.remap_en) begin
      remap_rd_q <= remap_mem[rd_i.remap_addr];
    end
  end

  assign rdata_o.next_state   = trans_rd_q;
  assign rdata_o.match_count  = info_rd_q[INFO_W-1:mpdfa_pkg::LIST_W];
  assign rdata_o.match_offset = info_rd_q[mpdfa_pkg::LIST_W-1:0];
  assign rdata_o.local_pid    = list_rd_q;
  assign rdata_o.global_id    = remap_rd_q;

endmodule

/* rtl/core/mpdfa_seq.sv */
module mpdfa_seq #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  mpdfa_pkg::req_t       req_i,
  output logic                  busy_o,
  output logic                  load_en_o,
  output mpdfa_pkg::tbl_rd_t    rd_o,
  input  mpdfa_pkg::tbl_rdata_t rdata_i,
  output logic                  res_valid_o,
  output mpdfa_pkg::res_t       res_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TRANS = 5'b00010,
    S_INFO  = 5'b00100,
    S_REMAP = 5'b01000,
    S_EMIT  = 5'b10000
  } seq_state_e;

  seq_state_e                     state_q, state_d;
  logic [mpdfa_pkg::STATE_W-1:0]  cur_state_q, cur_state_d;
  logic [POSITION_BITS-1:0]       pos_q, pos_d;
  logic                           text_end_q, text_end_d;
  logic [mpdfa_pkg::CNT_W-1:0]    n_q, n_d;
  logic [mpdfa_pkg::CNT_W-1:0]    k_q, k_d;
  logic [mpdfa_pkg::LIST_W-1:0]   off_q, off_d;
  logic [mpdfa_pkg::CNT_W-1:0]    n_sat;
  logic                           last_hit;
  logic                           finish;
  logic [mpdfa_pkg::END_POS_W-1:0] end_pos;

  assign busy_o    = (state_q != S_IDLE);
  assign load_en_o = start_i && !busy_o && (req_i.req_type != mpdfa_pkg::REQ_SCAN);

  assign n_sat = (rdata_i.match_count > mpdfa_pkg::MAX_OUTPUTS) ?
                 mpdfa_pkg::MAX_OUTPUTS : rdata_i.match_count;
  assign last_hit = ((k_q + mpdfa_pkg::CNT_W'(1)) == n_q);

  always_comb begin
    state_d     = state_q;
    cur_state_d = cur_state_q;
    pos_d       = pos_q;
    text_end_d  = text_end_q;
    n_d         = n_q;
    k_d         = k_q;
    off_d       = off_q;
    rd_o        = '0;
    res_valid_o = 1'b0;
    finish      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i && req_i.req_type == mpdfa_pkg::REQ_SCAN) begin
          rd_o.trans_en   = 1'b1;
          rd_o.trans_addr = {cur_state_q, req_i.byte_value};
          text_end_d      = req_i.text_end;
          state_d         = S_TRANS;
        end
      end
      S_TRANS: begin
        cur_state_d    = rdata_i.next_state;
        rd_o.info_en   = 1'b1;
        rd_o.info_addr = rdata_i.next_state;
        state_d        = S_INFO;
      end
      S_INFO: begin
        n_d   = n_sat;
        off_d = rdata_i.match_offset;
        k_d   = '0;
        if (n_sat == '0) begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end else begin
          rd_o.list_en   = 1'b1;
          rd_o.list_addr = rdata_i.match_offset;
          state_d        = S_REMAP;
        end
      end
      S_REMAP: begin
        rd_o.remap_en   = 1'b1;
        rd_o.remap_addr = rdata_i.local_pid;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        res_valid_o = 1'b1;
        if (last_hit) begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end else begin
          k_d            = k_q + mpdfa_pkg::CNT_W'(1);
          rd_o.list_en   = 1'b1;
          rd_o.list_addr = off_q + mpdfa_pkg::LIST_W'(k_q) + mpdfa_pkg::LIST_W'(1);
          state_d        = S_REMAP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (finish) begin
      if (text_end_q) begin
        cur_state_d = '0;
        pos_d       = '0;
      end else if (pos_q != '1) begin
        pos_d = pos_q + POSITION_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_state_q <= '0;
      pos_q       <= '0;
      text_end_q  <= 1'b0;
      n_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      cur_state_q <= cur_state_d;
      pos_q       <= pos_d;
      text_end_q  <= text_end_d;
      n_q         <= n_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
  end

  if (POSITION_BITS >= mpdfa_pkg::END_POS_W) begin : g_pos_trunc
    assign end_pos = pos_q[mpdfa_pkg::END_POS_W-1:0];
  end else begin : g_pos_ext
    assign end_pos = {{(mpdfa_pkg::END_POS_W - POSITION_BITS){1'b0}}, pos_q};
  end

  assign res_o.end_pos    = end_pos;
  assign res_o.match_pid  = rdata_i.global_id;
  assign res_o.last_match = last_hit;

endmodule

/* rtl/core/multi_pattern_dfa_matcher_top.sv */
// Load beats never raise busy. A scan beat keeps busy high through the transition
// and info reads, and, when patterns end, through a remap and emit step per pattern.
// Results are paced by the dependent transition, info, list and remap memory reads;
// each further result waits on its own list and remap reads.
// Results cannot be stalled. Reset clears state and position; tables hold
// nothing defined until loaded.
module multi_pattern_dfa_matcher_top #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  mpdfa_pkg::req_t req_i,
  output logic            res_valid_o,
  output mpdfa_pkg::res_t res_o
);

  logic                  load_en;
  mpdfa_pkg::tbl_rd_t    tbl_rd;
  mpdfa_pkg::tbl_rdata_t tbl_rdata;

  mpdfa_seq #(
    .POSITION_BITS(POSITION_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (req_i),
    .busy_o     (busy),
    .load_en_o  (load_en),
    .rd_o       (tbl_rd),
    .rdata_i    (tbl_rdata),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  mpdfa_tables u_tables (
    .clk_i    (clk_i),
    .load_en_i(load_en),
    .req_i    (req_i),
    .rd_i     (tbl_rd),
    .rdata_o  (tbl_rdata)
  );

`ifndef SYNTHESIS
  a_res_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy)
    else $error("result strobe outside a scan");

  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.req_type != mpdfa_pkg::REQ_SCAN) |=> !busy)
    else $error("load beat raised busy");

  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.req_type == mpdfa_pkg::REQ_SCAN) |=> (busy && !res_valid_o))
    else $error("scan beat did not start the sequencer");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 !res_valid_o)
    else $error("result too soon after a beat");
`endif

endmodule
